// ----- hdl/rau_pkg.sv -----
// package: transaction types, function codes and sequencer states for the rational unit
`default_nettype none
package rau_pkg;

   localparam int OPERAND_WIDTH_DEF = 32;
   localparam int PROD_W            = 64;

   typedef enum logic [2:0] {
      FN_ADD = 3'd0,
      FN_SUB = 3'd1,
      FN_MUL = 3'd2,
      FN_DIV = 3'd3,
      FN_CMP = 3'd4,
      FN_NEG = 3'd5,
      FN_RED = 3'd6,
      FN_NOP = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      REL_EQ = 2'd0,
      REL_GT = 2'd1,
      REL_LT = 2'd2
   } relation_type;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_num;
      logic [62:0]        result_den;
      logic [1:0]         relation;
      logic               fault;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_SUM,
      ST_GCD_START,
      ST_GCD_DIV,
      ST_GCD_STEP,
      ST_RED_N,
      ST_RED_D,
      ST_DIV_WAIT,
      ST_FINISH,
      ST_OUT
   } state_type;

   // handshake between sequencer and the shared divider
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage
`default_nettype wire

// ----- hdl/rau_divider.sv -----
// radix-2 restoring divider, one quotient bit per cycle, shared by gcd and reduction
`default_nettype none
module rau_divider
   import rau_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire div_ctl_type       ctl,
   input  wire logic [PROD_W-1:0] dividend,
   input  wire logic [PROD_W-1:0] divisor,
   output div_sts_type            sts,
   output logic [PROD_W-1:0]      quotient,
   output logic [PROD_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic [PROD_W-1:0] q_ff, q_in;
   logic [PROD_W-1:0] r_ff, r_in;
   logic [PROD_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PROD_W:0]   trial;
   logic [PROD_W:0]   shifted;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {r_ff, q_ff[PROD_W-1]};
      trial   = shifted - {1'b0, d_ff};
      if (ctl.start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = CNT_W'(PROD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[PROD_W]) begin
            r_in = trial[PROD_W-1:0];
            q_in = {q_ff[PROD_W-2:0], 1'b1};
         end else begin
            r_in = shifted[PROD_W-1:0];
            q_in = {q_ff[PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule
`default_nettype wire

// ----- hdl/rational_arithmetic_unit_core.sv -----
// top level: sequencer, shared multiplier and gcd reduction of signed fractions
// One transaction at a time. Operands are taken as sign and magnitude, up to three
// 32x32 products are formed one per cycle on a single multiplier, then the Euclidean
// gcd runs on the shared 64-step restoring divider, followed by two exact divisions of
// numerator and denominator by the gcd. Negate, faults and the unused code skip the
// gcd. The divider sets the rate.
// req_stall is high from acceptance until the result has been taken.
`default_nettype none
module rational_arithmetic_unit_core
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int MAG_W = OPERAND_WIDTH;

   state_type          state_ff, state_in;
   func_type           fn_ff, fn_in;
   logic [MAG_W-1:0]   an_ff, ad_ff, bn_ff, bd_ff;
   logic [MAG_W-1:0]   an_in, ad_in, bn_in, bd_in;
   logic               ans_ff, ads_ff, bns_ff, bds_ff;
   logic               ans_in, ads_in, bns_in, bds_in;
   logic [PROD_W-1:0]  p1_ff, p1_in, p2_ff, p2_in;
   logic               p1s_ff, p1s_in, p2s_ff, p2s_in;
   logic [PROD_W-1:0]  nm_ff, nm_in, dm_ff, dm_in;
   logic               ns_ff, ns_in;
   logic               red_ff, red_in;
   logic [PROD_W-1:0]  gx_ff, gx_in, gy_ff, gy_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rv_ff, rv_in;

   logic [MAG_W-1:0]   mul_x, mul_y;
   logic [PROD_W-1:0]  mul_p;
   div_ctl_type        dctl;
   div_sts_type        dsts;
   logic [PROD_W-1:0]  div_n, div_d, div_q, div_r;
   logic [PROD_W-1:0]  n_out;

   function automatic logic [MAG_W:0] to_sm(input logic [31:0] raw);
      logic [MAG_W-1:0] v;
      v = raw[MAG_W-1:0];
      if (v[MAG_W-1]) return {1'b1, (~v) + 1'b1};
      return {1'b0, v};
   endfunction

   // single shared multiplier, magnitudes only
   assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

   rau_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dctl),
      .dividend  (div_n),
      .divisor   (div_d),
      .sts       (dsts),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign n_out = ns_ff ? (PROD_W'(0) - nm_ff) : nm_ff;

   always_comb begin
      state_in = state_ff;
      fn_in  = fn_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      ans_in = ans_ff; ads_in = ads_ff; bns_in = bns_ff; bds_in = bds_ff;
      p1_in = p1_ff; p1s_in = p1s_ff; p2_in = p2_ff; p2s_in = p2s_ff;
      nm_in = nm_ff; dm_in = dm_ff; ns_in = ns_ff; red_in = red_ff;
      gx_in = gx_ff; gy_in = gy_ff;
      rsp_in = rsp_ff;
      rv_in  = rv_ff;
      mul_x = an_ff; mul_y = bd_ff;
      dctl.start = 1'b0;
      div_n = gx_ff; div_d = gy_ff;
      req_stall = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fn_in = func_type'(req_data.func);
               {ans_in, an_in} = to_sm(req_data.a_num);
               {ads_in, ad_in} = to_sm(req_data.a_den);
               {bns_in, bn_in} = to_sm(req_data.b_num);
               {bds_in, bd_in} = to_sm(req_data.b_den);
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            // a_num * b_num for multiply, a_num * b_den otherwise
            mul_x = an_ff;
            mul_y = (fn_ff == FN_MUL) ? bn_ff : bd_ff;
            p1_in  = mul_p;
            p1s_in = (ans_ff != ((fn_ff == FN_MUL) ? bns_ff : bds_ff));
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            // second term: a_den * b_num
            mul_x = ad_ff;
            mul_y = bn_ff;
            p2_in  = mul_p;
            p2s_in = (ads_ff != bns_ff) ^ ((fn_ff == FN_SUB) || (fn_ff == FN_CMP));
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            // denominator product a_den * b_den
            mul_x = ad_ff;
            mul_y = bd_ff;
            red_in = 1'b1;
            unique case (fn_ff)
               FN_ADD, FN_SUB, FN_CMP: begin
                  dm_in = mul_p;
                  ns_in = ads_ff != bds_ff;
                  state_in = ST_SUM;
               end
               FN_MUL: begin
                  nm_in = p1_ff;
                  dm_in = mul_p;
                  ns_in = p1s_ff != (ads_ff != bds_ff);
                  state_in = ST_GCD_START;
               end
               FN_DIV: begin
                  nm_in = p1_ff;
                  dm_in = p2_ff;
                  ns_in = (ans_ff != bds_ff) != (ads_ff != bns_ff);
                  state_in = ST_GCD_START;
               end
               FN_NEG, FN_RED: begin
                  nm_in = PROD_W'(an_ff);
                  dm_in = PROD_W'(ad_ff);
                  ns_in = (ans_ff ^ (fn_ff == FN_NEG)) != ads_ff;
                  red_in = (fn_ff == FN_RED);
                  state_in = ST_GCD_START;
               end
               default: begin
                  rsp_in = '0;
                  rsp_in.result_den = 63'd1;
                  rv_in = 1'b1;
                  state_in = ST_OUT;
               end
            endcase
            if (fn_ff == FN_DIV && bn_ff == '0) begin
               rsp_in = '0;
               rsp_in.fault = 1'b1;
               rv_in = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_SUM: begin
            // signed sum of the two cross terms, sign of den folded in ns
            if (p1s_ff == p2s_ff) begin
               nm_in = p1_ff + p2_ff;
               ns_in = ns_ff != p1s_ff;
            end else if (p1_ff >= p2_ff) begin
               nm_in = p1_ff - p2_ff;
               ns_in = ns_ff != p1s_ff;
            end else begin
               nm_in = p2_ff - p1_ff;
               ns_in = ns_ff != p2s_ff;
            end
            state_in = ST_GCD_START;
         end
         ST_GCD_START: begin
            if (dm_ff == '0) begin
               rsp_in = '0;
               rsp_in.fault = 1'b1;
               rv_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               gx_in = nm_ff;
               gy_in = dm_ff;
               state_in = red_ff ? ST_GCD_STEP : ST_FINISH;
            end
         end
         ST_GCD_STEP: begin
            if (gy_ff == '0) begin
               // gx holds the gcd, nonzero as dm is nonzero
               div_n = nm_ff;
               div_d = gx_ff;
               dctl.start = 1'b1;
               state_in = ST_RED_N;
            end else begin
               dctl.start = 1'b1;
               state_in = ST_GCD_DIV;
            end
         end
         ST_GCD_DIV: begin
            if (dsts.done) begin
               gx_in = gy_ff;
               gy_in = div_r;
               state_in = ST_GCD_STEP;
            end
         end
         ST_RED_N: begin
            if (dsts.done) begin
               nm_in = div_q;
               div_n = dm_ff;
               div_d = gx_ff;
               dctl.start = 1'b1;
               state_in = ST_RED_D;
            end
         end
         ST_RED_D: begin
            if (dsts.done) begin
               dm_in = div_q;
               state_in = ST_FINISH;
            end
         end
         ST_DIV_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_in = '0;
            rsp_in.result_num = (nm_ff == '0) ? '0 : n_out;
            rsp_in.result_den = dm_ff[62:0];
            if (fn_ff == FN_CMP && nm_ff != '0)
               rsp_in.relation = ns_ff ? REL_LT : REL_GT;
            rv_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rv_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      fn_ff <= fn_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      ans_ff <= ans_in; ads_ff <= ads_in; bns_ff <= bns_in; bds_ff <= bds_in;
      p1_ff <= p1_in; p1s_ff <= p1s_in; p2_ff <= p2_in; p2s_ff <= p2s_in;
      nm_ff <= nm_in; dm_ff <= dm_in; ns_ff <= ns_in; red_ff <= red_in;
      gx_ff <= gx_in; gy_ff <= gy_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ----- hdl/rau_checker.sv -----
// port checker for the rational unit, bound to the top level
`default_nettype none
module rau_checker
   import rau_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a result never sits beside a new transaction being taken
   a_no_accept_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // fault results are always 0/0
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault |-> rsp_data.result_num == '0 && rsp_data.result_den == '0)
      else $error("fault with nonzero fraction");

   a_accept_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("not busy after transaction taken");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
